>>> rtl/core/tam_pkg.sv
`default_nettype none

package tam_pkg;

   // Instruction codes
   typedef enum logic [3:0] {
      OP_ADDI = 4'd0,
      OP_ADD  = 4'd1,
      OP_SUBI = 4'd2,
      OP_SUB  = 4'd3,
      OP_DMEM = 4'd4,
      OP_LDUR = 4'd5,
      OP_STUR = 4'd6,
      OP_CBZ  = 4'd7,
      OP_B    = 4'd8
   } op_type;

   // Cycle counter value after reset (pipeline fill)
   localparam logic [31:0] CYCLE_RESET = 32'd3;

   // One instruction transaction
   typedef struct packed {
      logic [3:0]         op;
      logic signed [31:0] field_a;
      logic signed [31:0] field_b;
      logic [4:0]         field_c;
      logic               has_next;
      logic [3:0]         next_op;
      logic signed [31:0] next_a;
      logic signed [31:0] next_b;
   } req_payload_type;

   // One result transaction
   typedef struct packed {
      logic [7:0]         next_pc;
      logic               reg_write;
      logic [4:0]         reg_index;
      logic signed [31:0] reg_value;
      logic               mem_write;
      logic [2:0]         mem_index;
      logic signed [31:0] mem_value;
      logic [31:0]        cycle_count;
   } rsp_payload_type;

   // Instruction fields carried down the pipeline
   typedef struct packed {
      logic [3:0]  op;
      logic [31:0] field_a;
      logic [31:0] field_b;
      logic        has_next;
      logic        hz_match;   // load/store feeding the next ALU op
      logic        off_zero;   // branch offset is zero
   } inst_type;

   function automatic logic is_alu_op(input logic [3:0] op);
      return (op == OP_ADDI) || (op == OP_ADD) || (op == OP_SUBI) || (op == OP_SUB);
   endfunction

   function automatic logic is_ldst_op(input logic [3:0] op);
      return (op == OP_LDUR) || (op == OP_STUR);
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/tam_ifs.sv
`default_nettype none

// Instruction channel
interface tam_req_if import tam_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// Result channel
interface tam_rsp_if import tam_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/core/toy_arm_subset_executor.sv
// Executes one pre-decoded instruction per transaction on the req_chan
// channel and returns one result per instruction on rsp_chan, in order.
// Each request carries the instruction plus opcode and two operands of the
// instruction that follows it, which feed the stall-cycle accounting.
// Both channels use valid/ready; a transaction moves when both are high.
// Throughput: one instruction per clock while rsp_chan.ready is high and the
// reset sweep is done; the register file has a single write port.
// Pipeline: an instruction passes the input register, index reduction and
// operand read registers, then executes into the result register.
// Reset: synchronous. After reset, register file and data memory are
// swept to zero, one entry per cycle; req_chan.ready stays low until the
// sweep is done.
// Receiver stall: the result register holds while rsp_chan.ready is low and
// the pipeline fills behind it; req_chan.ready drops once every stage holds
// an instruction, and nothing is dropped or repeated.
`default_nettype none

module toy_arm_subset_executor import tam_pkg::*; #(
   parameter int REG_COUNT  = 32,
   parameter int DMEM_DEPTH = 8,
   parameter int PROG_DEPTH = 256
) (
   input wire logic    clock,
   input wire logic    reset,
   tam_req_if.sink     req_chan,
   tam_rsp_if.source   rsp_chan
);

   localparam int RIDX_W = $clog2(REG_COUNT);
   localparam int MIDX_W = $clog2(DMEM_DEPTH);
   localparam int PC_W   = $clog2(PROG_DEPTH);

   logic s0_v_ff, s0_v_in;
   logic s1_v_ff, s1_v_in;
   logic s2_v_ff, s2_v_in;
   logic rsp_v_ff, rsp_v_in;

   req_payload_type req_ff;
   logic [31:0]     mag_ff;
   logic [31:0]     mag_in;
   inst_type        inst_ff;
   inst_type        inst_in;
   rsp_payload_type rsp_ff;
   rsp_payload_type result;

   logic              out_free;
   logic              fire;
   logic              s2_free;
   logic              s1_move;
   logic              s1_free;
   logic              s0_move;
   logic              s0_free;
   logic              req_take;
   logic              clearing;
   logic [31:0]       off_src;
   logic [31:0]       off_abs;
   logic [RIDX_W-1:0] ra_idx;
   logic [RIDX_W-1:0] rb_idx;
   logic [RIDX_W-1:0] rc_idx;
   logic [MIDX_W-1:0] dm_idx;
   logic [PC_W-1:0]   pc_red;

   // Pipeline handshake
   always_comb begin
      out_free       = !rsp_v_ff || rsp_chan.ready;
      fire           = s2_v_ff && out_free;
      s2_free        = !s2_v_ff || fire;
      s1_move        = s1_v_ff && s2_free;
      s1_free        = !s1_v_ff || s1_move;
      s0_move        = s0_v_ff && s1_free;
      s0_free        = !s0_v_ff || s0_move;
      req_chan.ready = s0_free && !clearing;
      req_take       = req_chan.valid && s0_free && !clearing;
      s0_v_in        = req_take || (s0_v_ff && !s0_move);
      s1_v_in        = s0_move || (s1_v_ff && !s1_move);
      s2_v_in        = s1_move || (s2_v_ff && !fire);
      rsp_v_in       = fire || (rsp_v_ff && !rsp_chan.ready);
      rsp_chan.valid   = rsp_v_ff;
      rsp_chan.payload = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff  <= 1'b0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         s0_v_ff  <= s0_v_in;
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   // Branch distance to subtract from the PC: -offset if negative, else offset+1
   always_comb begin
      off_src = (req_chan.payload.op == OP_CBZ) ? req_chan.payload.field_b
                                                : req_chan.payload.field_a;
      off_abs = off_src[31] ? ~off_src : off_src;
      mag_in  = off_abs + 32'd1;
   end

   // Fields passed to the execute stage, with the load-use compare done early
   always_comb begin
      inst_in.op       = req_ff.op;
      inst_in.field_a  = req_ff.field_a;
      inst_in.field_b  = req_ff.field_b;
      inst_in.has_next = req_ff.has_next;
      inst_in.hz_match = is_ldst_op(req_ff.op) && is_alu_op(req_ff.next_op) &&
                         (({27'b0, req_ff.field_c} == req_ff.next_a) ||
                          ({27'b0, req_ff.field_c} == req_ff.next_b));
      inst_in.off_zero = (mag_ff == 32'd1) && !req_ff.has_next && 1'b0 ||
                         (((req_ff.op == OP_CBZ) ? req_ff.field_b : req_ff.field_a) == '0);
   end

   // Stage payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_chan.payload;
         mag_ff <= mag_in;
      end
      if (s0_move) begin
         inst_ff <= inst_in;
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   // Index reduction units
   tam_modidx #(.DIVISOR(REG_COUNT)) u_mod_ra (
      .clock (clock),
      .load  (s0_move),
      .value (req_ff.field_a),
      .index (ra_idx)
   );

   tam_modidx #(.DIVISOR(REG_COUNT)) u_mod_rb (
      .clock (clock),
      .load  (s0_move),
      .value (req_ff.field_b),
      .index (rb_idx)
   );

   tam_modidx #(.DIVISOR(REG_COUNT)) u_mod_rc (
      .clock (clock),
      .load  (s0_move),
      .value ({27'b0, req_ff.field_c}),
      .index (rc_idx)
   );

   tam_modidx #(.DIVISOR(DMEM_DEPTH)) u_mod_dm (
      .clock (clock),
      .load  (s0_move),
      .value (req_ff.field_a),
      .index (dm_idx)
   );

   tam_modidx #(.DIVISOR(PROG_DEPTH)) u_mod_pc (
      .clock (clock),
      .load  (s0_move),
      .value (mag_ff),
      .index (pc_red)
   );

   // Operand read and execute
   tam_exec #(
      .REG_COUNT  (REG_COUNT),
      .DMEM_DEPTH (DMEM_DEPTH),
      .PROG_DEPTH (PROG_DEPTH)
   ) u_exec (
      .clock    (clock),
      .reset    (reset),
      .s2_load  (s1_move),
      .fire     (fire),
      .s1_inst  (inst_ff),
      .ra_idx   (ra_idx),
      .rb_idx   (rb_idx),
      .rc_idx   (rc_idx),
      .dm_idx   (dm_idx),
      .pc_red   (pc_red),
      .result   (result),
      .clearing (clearing)
   );

endmodule

`default_nettype wire

>>> rtl/core/tam_modidx.sv
`default_nettype none

// Two-stage reduction of a 32-bit value modulo a constant.
// Stage 1 (registered on load): quotient estimate by reciprocal multiply.
// Stage 2 (combinational from the registers): remainder with one correction.
module tam_modidx #(
   parameter int DIVISOR = 32
) (
   input  wire logic                       clock,
   input  wire logic                       load,
   input  wire logic [31:0]                value,
   output logic      [$clog2(DIVISOR)-1:0] index
);

   localparam int IDX_W = $clog2(DIVISOR);
   localparam int SHIFT = 32 + IDX_W;
   localparam logic [32:0]    RECIP  = 33'((65'd1 << SHIFT) / DIVISOR);
   localparam logic [IDX_W:0] DIV_LO = (IDX_W+1)'(DIVISOR);

   logic [64:0]          product;
   logic [IDX_W:0]       quo_ff;
   logic [IDX_W:0]       low_ff;
   logic [2*IDX_W+1:0]   qn_full;
   logic [IDX_W:0]       est;
   logic [IDX_W:0]       est_sub;

   // Quotient estimate is exact or one low; only its low bits matter
   always_comb begin
      product = {33'b0, value} * {32'b0, RECIP};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         quo_ff <= product[SHIFT +: IDX_W+1];
         low_ff <= value[IDX_W:0];
      end
   end

   // Remainder estimate lies in [0, 2*DIVISOR)
   always_comb begin
      qn_full = {{(IDX_W+1){1'b0}}, quo_ff} * {{(IDX_W+1){1'b0}}, DIV_LO};
      est     = low_ff - qn_full[IDX_W:0];
      est_sub = est - DIV_LO;
      index   = (est >= DIV_LO) ? est_sub[IDX_W-1:0] : est[IDX_W-1:0];
   end

endmodule

`default_nettype wire

>>> rtl/core/tam_exec.sv
`default_nettype none

// Execute stage: register file, data memory, architectural counters.
// Operand reads are issued on s2_load with registered data; a write retiring
// on the same edge is forwarded through a hit flag.
module tam_exec import tam_pkg::*; #(
   parameter int REG_COUNT  = 32,
   parameter int DMEM_DEPTH = 8,
   parameter int PROG_DEPTH = 256
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          s2_load,
   input  wire logic                          fire,
   input  wire inst_type                      s1_inst,
   input  wire logic [$clog2(REG_COUNT)-1:0]  ra_idx,
   input  wire logic [$clog2(REG_COUNT)-1:0]  rb_idx,
   input  wire logic [$clog2(REG_COUNT)-1:0]  rc_idx,
   input  wire logic [$clog2(DMEM_DEPTH)-1:0] dm_idx,
   input  wire logic [$clog2(PROG_DEPTH)-1:0] pc_red,
   output rsp_payload_type                    result,
   output logic                               clearing
);

   localparam int RIDX_W = $clog2(REG_COUNT);
   localparam int MIDX_W = $clog2(DMEM_DEPTH);
   localparam int PC_W   = $clog2(PROG_DEPTH);
   localparam int CLR_N  = (REG_COUNT > DMEM_DEPTH) ? REG_COUNT : DMEM_DEPTH;
   localparam int CLR_W  = $clog2(CLR_N);

   // Storage
   logic [31:0] rf_mem [REG_COUNT];
   logic [31:0] dm_mem [DMEM_DEPTH];

   // Execute-stage registers
   inst_type          inst_ff;
   logic [RIDX_W-1:0] c_idx_ff;
   logic [MIDX_W-1:0] m_idx_ff;
   logic [PC_W-1:0]   pcr_ff;
   logic [31:0]       rd0_ff;
   logic [31:0]       rd1_ff;
   logic [31:0]       rdm_ff;
   logic              hit0_ff;
   logic              hit1_ff;
   logic              hitm_ff;
   logic [31:0]       fwd_reg_ff;
   logic [31:0]       fwd_mem_ff;

   // Architectural state
   logic [PC_W-1:0]   pc_ff;
   logic [31:0]       cyc_ff;
   logic              prevbr_ff;
   logic              pend_ff;
   logic              clr_ff;
   logic [CLR_W-1:0]  clr_cnt_ff;

   logic [RIDX_W-1:0] raddr0;
   logic              clr_rf;
   logic              clr_dm;
   logic [31:0]       src0;
   logic [31:0]       src1;
   logic [31:0]       mdat;
   logic              wr_reg;
   logic              wr_mem;
   logic [31:0]       reg_val;
   logic [31:0]       mem_val;
   logic              reg_we;
   logic              mem_we;
   logic              cbz_zero;
   logic              jump;
   logic              pend_used;
   logic              branch_bub;
   logic              bubble;
   logic [1:0]        delta;
   logic [31:0]       cyc_in;
   logic              pend_in;
   logic              prevbr_in;
   logic [PC_W-1:0]   pc_step;
   logic [PC_W:0]     pc_wrap;
   logic [PC_W-1:0]   pc_back;
   logic [PC_W-1:0]   pc_in;
   logic [PC_W+7:0]   pc_wide;
   logic [RIDX_W+4:0] ri_wide;
   logic [MIDX_W+2:0] mi_wide;

   // Read port 0 serves the source register, or the store data for STUR
   always_comb begin
      raddr0 = (s1_inst.op == OP_STUR) ? rc_idx : rb_idx;
      clr_rf = clr_ff && ({1'b0, clr_cnt_ff} < (CLR_W+1)'(REG_COUNT));
      clr_dm = clr_ff && ({1'b0, clr_cnt_ff} < (CLR_W+1)'(DMEM_DEPTH));
   end

   // Register file: one write, two registered reads
   always_ff @(posedge clock) begin
      if (clr_rf) begin
         rf_mem[clr_cnt_ff[RIDX_W-1:0]] <= '0;
      end else if (reg_we) begin
         rf_mem[c_idx_ff] <= reg_val;
      end
      if (s2_load) begin
         rd0_ff <= rf_mem[raddr0];
         rd1_ff <= rf_mem[ra_idx];
      end
   end

   // Data memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (clr_dm) begin
         dm_mem[clr_cnt_ff[MIDX_W-1:0]] <= '0;
      end else if (mem_we) begin
         dm_mem[m_idx_ff] <= mem_val;
      end
      if (s2_load) begin
         rdm_ff <= dm_mem[dm_idx];
      end
   end

   // Stage payload and forwarding from the retiring instruction
   always_ff @(posedge clock) begin
      if (s2_load) begin
         inst_ff    <= s1_inst;
         c_idx_ff   <= rc_idx;
         m_idx_ff   <= dm_idx;
         pcr_ff     <= pc_red;
         hit0_ff    <= reg_we && (c_idx_ff == raddr0);
         hit1_ff    <= reg_we && (c_idx_ff == ra_idx);
         hitm_ff    <= mem_we && (m_idx_ff == dm_idx);
         fwd_reg_ff <= reg_val;
         fwd_mem_ff <= mem_val;
      end
   end

   // Instruction semantics
   always_comb begin
      src0     = hit0_ff ? fwd_reg_ff : rd0_ff;
      src1     = hit1_ff ? fwd_reg_ff : rd1_ff;
      mdat     = hitm_ff ? fwd_mem_ff : rdm_ff;
      wr_reg   = 1'b0;
      wr_mem   = 1'b0;
      reg_val  = '0;
      mem_val  = '0;
      cbz_zero = 1'b0;
      jump     = 1'b0;
      case (inst_ff.op)
         OP_ADDI: begin
            wr_reg  = 1'b1;
            reg_val = src0 + inst_ff.field_a;
         end
         OP_SUBI: begin
            wr_reg  = 1'b1;
            reg_val = src0 - inst_ff.field_a;
         end
         OP_ADD: begin
            wr_reg  = 1'b1;
            reg_val = src0 + src1;
         end
         OP_SUB: begin
            wr_reg  = 1'b1;
            reg_val = src0 - src1;
         end
         OP_DMEM: begin
            wr_mem  = 1'b1;
            mem_val = inst_ff.field_b;
         end
         OP_LDUR: begin
            wr_reg  = 1'b1;
            reg_val = mdat;
         end
         OP_STUR: begin
            wr_mem  = 1'b1;
            mem_val = src0;
         end
         OP_CBZ: begin
            cbz_zero = (src1 == '0);
            jump     = cbz_zero && !inst_ff.off_zero;
         end
         OP_B: begin
            jump = !inst_ff.off_zero;
         end
         default: begin
            jump = 1'b0;
         end
      endcase
      reg_we = fire && wr_reg;
      mem_we = fire && wr_mem;
   end

   // Cycle accounting: pending branch bubble, load-use and branch bubbles, less one for a CBZ on a zero register
   always_comb begin
      pend_used  = inst_ff.has_next && pend_ff;
      branch_bub = inst_ff.has_next && (pc_ff > PC_W'(1)) && prevbr_ff;
      bubble     = (inst_ff.has_next && inst_ff.hz_match) || branch_bub;
      delta      = 2'd1 + {1'b0, pend_used} + {1'b0, bubble} - {1'b0, cbz_zero};
      cyc_in     = cyc_ff + {30'b0, delta};
      pend_in    = branch_bub || (pend_ff && !inst_ff.has_next);
      prevbr_in  = (inst_ff.op == OP_CBZ) || (inst_ff.op == OP_B);
   end

   // Next PC; the branch distance arrives already reduced modulo the depth
   always_comb begin
      pc_step = (pc_ff == PC_W'(PROG_DEPTH - 1)) ? '0 : pc_ff + PC_W'(1);
      pc_wrap = (PC_W+1)'(PROG_DEPTH) + {1'b0, pc_ff} - {1'b0, pcr_ff};
      pc_back = (pc_ff >= pcr_ff) ? (pc_ff - pcr_ff) : pc_wrap[PC_W-1:0];
      pc_in   = jump ? pc_back : pc_step;
   end

   // Result fields
   always_comb begin
      pc_wide = {8'b0, pc_in};
      ri_wide = {5'b0, c_idx_ff};
      mi_wide = {3'b0, m_idx_ff};
      result.next_pc     = pc_wide[7:0];
      result.reg_write   = wr_reg;
      result.reg_index   = wr_reg ? ri_wide[4:0] : 5'b0;
      result.reg_value   = reg_val;
      result.mem_write   = wr_mem;
      result.mem_index   = wr_mem ? mi_wide[2:0] : 3'b0;
      result.mem_value   = mem_val;
      result.cycle_count = cyc_in;
      clearing           = clr_ff;
   end

   // Architectural state and post-reset clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff      <= '0;
         cyc_ff     <= CYCLE_RESET;
         prevbr_ff  <= 1'b0;
         pend_ff    <= 1'b0;
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
      end else begin
         if (clr_ff) begin
            clr_cnt_ff <= clr_cnt_ff + CLR_W'(1);
            if (clr_cnt_ff == CLR_W'(CLR_N - 1)) begin
               clr_ff <= 1'b0;
            end
         end
         if (fire) begin
            pc_ff     <= pc_in;
            cyc_ff    <= cyc_in;
            prevbr_ff <= prevbr_in;
            pend_ff   <= pend_in;
         end
      end
   end

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tam_pkg::*;

   // Opcode range with no defined instruction
   localparam logic [3:0] OP_UNDEF_LO = 4'd9;
   localparam logic [3:0] OP_UNDEF_HI = 4'd15;

   localparam int HOLD_CYCLES   = 80;
   localparam int RANDOM_ITEMS  = 730;
   localparam int NOISE_ITEMS   = 70;
   localparam int DRAIN_CYCLES  = 8;
   localparam int TIMEOUT_NS    = 400_000;
   localparam int MAX_REPORTS   = 10;

   typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_type;

   logic clock;
   logic reset;

   tam_req_if req_if ();
   tam_rsp_if rsp_if ();

   toy_arm_subset_executor i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source)
   );

   // Architectural shadow state of the executor
   logic [31:0] gpr [32];
   logic [31:0] dmem [8];
   logic [7:0]  pc;
   logic [31:0] cycles;
   bit          last_was_branch;
   bit          bubble_owed;

   rsp_payload_type exec_results_q [$];

   // Traffic control
   bit          sender_gaps;
   int          burst_left;
   rx_mode_type rx_mode;
   logic [7:0]  rx_pattern;
   bit          rx_hold;

   int issued;
   int checked;
   int mismatches;
   int n_taken;
   int n_bubbles;

   always #1 clock = ~clock;

   // Execute one instruction on the shadow state and return the expected result
   function automatic rsp_payload_type execute_instr(req_payload_type t);
      rsp_payload_type r;
      logic [31:0]     ra_val;
      logic [31:0]     rb_val;
      longint          jump;
      longint          dest;
      bit              bubble;
      r      = '0;
      jump   = 0;
      bubble = 0;

      // stall accounting looks at the following instruction
      if (t.has_next) begin
         if (bubble_owed) begin
            cycles++;
            bubble_owed = 0;
         end
         if (t.op inside {OP_LDUR, OP_STUR} &&
             t.next_op inside {OP_ADDI, OP_ADD, OP_SUBI, OP_SUB} &&
             ({27'd0, t.field_c} == t.next_a || {27'd0, t.field_c} == t.next_b))
            bubble = 1;
         if (pc > 1 && last_was_branch) begin
            bubble      = 1;
            bubble_owed = 1;
         end
         if (bubble) begin
            cycles++;
            n_bubbles++;
         end
      end

      ra_val = gpr[t.field_a[4:0]];
      rb_val = gpr[t.field_b[4:0]];
      case (t.op)
         OP_ADDI, OP_SUBI, OP_ADD, OP_SUB, OP_LDUR: begin
            r.reg_write = 1'b1;
            r.reg_index = t.field_c;
            case (t.op)
               OP_ADDI: r.reg_value = rb_val + t.field_a;
               OP_SUBI: r.reg_value = rb_val - t.field_a;
               OP_ADD:  r.reg_value = rb_val + ra_val;
               OP_SUB:  r.reg_value = rb_val - ra_val;
               default: r.reg_value = dmem[t.field_a[2:0]];
            endcase
         end
         OP_DMEM, OP_STUR: begin
            r.mem_write = 1'b1;
            r.mem_index = t.field_a[2:0];
            r.mem_value = (t.op == OP_DMEM) ? t.field_b : gpr[t.field_c];
         end
         OP_CBZ: begin
            if (ra_val == 0) begin
               jump = longint'($signed(t.field_b));
               cycles--;
               n_taken++;
            end
         end
         OP_B: begin
            jump = longint'($signed(t.field_a));
         end
         default: ;
      endcase

      if (r.reg_write) gpr[r.reg_index] = r.reg_value;
      if (r.mem_write) dmem[r.mem_index] = r.mem_value;
      cycles++;

      // odd branch rule: forward offsets move the PC back
      if (jump < 0)
         dest = longint'(pc) + jump;
      else if (jump > 0)
         dest = longint'(pc) - jump - 1;
      else
         dest = longint'(pc) + 1;
      pc = dest[7:0];
      last_was_branch = (t.op == OP_CBZ) || (t.op == OP_B);

      r.next_pc     = pc;
      r.cycle_count = cycles;
      return r;
   endfunction

   function automatic req_payload_type mk(logic [3:0] op, logic [31:0] a, logic [31:0] b,
                                          logic [4:0] c, logic hn = 1'b0,
                                          logic [3:0] nop = OP_ADDI,
                                          logic [31:0] na = '0, logic [31:0] nb = '0);
      req_payload_type t;
      t.op       = op;
      t.field_a  = a;
      t.field_b  = b;
      t.field_c  = c;
      t.has_next = hn;
      t.next_op  = nop;
      t.next_a   = na;
      t.next_b   = nb;
      return t;
   endfunction

   // Mostly small values around zero, sometimes extremes or full random
   function automatic logic [31:0] rand_operand(int span);
      case ($urandom_range(0, 7))
         0: return $urandom();
         1: begin
            case ($urandom_range(0, 3))
               0:       return 32'h7FFF_FFFF;
               1:       return 32'h8000_0000;
               2:       return 32'hFFFF_FFFF;
               default: return 32'h0;
            endcase
         end
         default: return 32'($urandom_range(0, 2 * span)) - 32'(span);
      endcase
   endfunction

   function automatic req_payload_type rand_instr();
      req_payload_type t;
      t = '0;
      if ($urandom_range(0, 15) == 0)
         t.op = 4'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
      else
         t.op = 4'($urandom_range(OP_ADDI, OP_B));
      t.field_c = 5'($urandom_range(0, 31));
      case (t.op)
         OP_ADDI, OP_SUBI: begin
            t.field_a = rand_operand(1000);
            t.field_b = rand_operand(31);
         end
         OP_ADD, OP_SUB: begin
            t.field_a = rand_operand(31);
            t.field_b = rand_operand(31);
         end
         OP_DMEM: begin
            t.field_a = rand_operand(7);
            t.field_b = rand_operand(100000);
         end
         OP_LDUR, OP_STUR: begin
            t.field_a = rand_operand(7);
            t.field_b = rand_operand(31);
         end
         OP_CBZ: begin
            t.field_a = rand_operand(31);
            t.field_b = rand_operand(6);
         end
         OP_B: begin
            t.field_a = rand_operand(6);
            t.field_b = $urandom();
         end
         default: begin
            t.field_a = $urandom();
            t.field_b = $urandom();
         end
      endcase
      return t;
   endfunction

   // Offer one transaction, wait for acceptance, record its expected result
   task automatic issue_instr(req_payload_type t);
      @(negedge clock);
      if (sender_gaps && burst_left == 0) begin
         burst_left   = $urandom_range(1, 12);
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      if (burst_left > 0) burst_left--;
      req_if.payload = t;
      req_if.valid   = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      exec_results_q = {exec_results_q, execute_instr(t)};
      issued++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (exec_results_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Well-formed program: next-instruction fields mirror the real successor
   task automatic run_program(int len);
      req_payload_type prog [$];
      req_payload_type t;
      while (prog.size() < len) begin
         t = rand_instr();
         // clear the tested register so that CBZ is often taken
         if (t.op == OP_CBZ && $urandom_range(0, 1))
            prog = {prog, mk(OP_SUB, t.field_a, t.field_a, t.field_a[4:0])};
         prog = {prog, t};
         // load/store feeding the next ALU op
         if (t.op inside {OP_LDUR, OP_STUR} && $urandom_range(0, 1))
            prog = {prog, mk(OP_ADD, {27'd0, t.field_c}, rand_operand(31),
                             5'($urandom_range(0, 31)))};
      end
      foreach (prog[i]) begin
         if (i + 1 < prog.size()) begin
            prog[i].has_next = 1'b1;
            prog[i].next_op  = prog[i + 1].op;
            prog[i].next_a   = prog[i + 1].field_a;
            prog[i].next_b   = prog[i + 1].field_b;
         end else begin
            prog[i].has_next = 1'b0;
            prog[i].next_op  = 4'($urandom_range(0, 15));
            prog[i].next_a   = $urandom();
            prog[i].next_b   = $urandom();
         end
      end
      foreach (prog[i]) issue_instr(prog[i]);
   endtask

   // Operand extremes, every opcode, hazards, branch rule corners
   task automatic test_directed();
      sender_gaps = 0;
      rx_mode     = RX_ALWAYS;
      issue_instr(mk(OP_DMEM, 32'h0, 32'h7FFF_FFFF, 5'd0));
      // address wraps to the last word
      issue_instr(mk(OP_DMEM, 32'hFFFF_FFFF, 32'h8000_0000, 5'd31));
      // load-use on next_a, then on next_b
      issue_instr(mk(OP_LDUR, 32'h0, 32'h0, 5'd1, 1'b1, OP_ADDI, 32'd1, 32'd0));
      issue_instr(mk(OP_LDUR, 32'hF, 32'hFFFF_FFFF, 5'd31, 1'b1, OP_SUB, 32'd5, 32'd31));
      issue_instr(mk(OP_ADDI, 32'h7FFF_FFFF, 32'd1, 5'd2, 1'b1, OP_ADD, 32'd2, 32'd2));
      issue_instr(mk(OP_ADDI, 32'h8000_0000, 32'd31, 5'd3));
      issue_instr(mk(OP_SUBI, 32'd1, 32'd0, 5'd0));
      issue_instr(mk(OP_ADD, 32'd2, 32'd3, 5'd4));
      // register indexes wrap
      issue_instr(mk(OP_SUB, 32'hFFFF_FFFF, 32'd64, 5'd5));
      issue_instr(mk(OP_STUR, 32'hFFFF_FFFF, 32'h0, 5'd31, 1'b1, OP_ADD, 32'd31, 32'd0));
      // next is a load, no hazard class
      issue_instr(mk(OP_STUR, 32'd3, 32'h0, 5'd4, 1'b1, OP_LDUR, 32'd4, 32'd4));
      // operands compare as full signed words, so no match here
      issue_instr(mk(OP_LDUR, 32'd1, 32'h0, 5'd31, 1'b1, OP_ADDI,
                     32'hFFFF_FFFF, 32'h8000_001F));
      // zero register: taken backward
      issue_instr(mk(OP_CBZ, 32'd6, 32'hFFFF_FFFE, 5'd0, 1'b1, OP_B, 32'h0, 32'h0));
      // nonzero register: not taken
      issue_instr(mk(OP_CBZ, 32'd2, 32'd5, 5'd0, 1'b1, OP_ADD, 32'h0, 32'h0));
      issue_instr(mk(OP_B, 32'h0, 32'h0, 5'd0, 1'b1, OP_B, 32'h0, 32'h0));
      issue_instr(mk(OP_B, 32'd3, 32'h0, 5'd0, 1'b1, OP_ADDI, 32'h0, 32'h0));
      // huge offset, PC wraps
      issue_instr(mk(OP_B, 32'h8000_0000, 32'h0, 5'd0, 1'b1, OP_SUBI, 32'h0, 32'h0));
      issue_instr(mk(OP_CBZ, 32'd7, 32'h0, 5'd0, 1'b1, OP_SUBI, 32'h0, 32'h0));
      issue_instr(mk(OP_CBZ, 32'd8, 32'h7FFF_FFFF, 5'd0, 1'b1, OP_ADD, 32'h0, 32'h0));
      // undefined opcodes
      issue_instr(mk(OP_UNDEF_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 1'b1, OP_UNDEF_HI,
                     32'd31, 32'd31));
      issue_instr(mk(OP_UNDEF_HI, 32'h0, 32'h0, 5'd0, 1'b1, OP_ADD, 32'h0, 32'h0));
      // last instruction of the program
      issue_instr(mk(OP_ADDI, 32'h0, 32'h0, 5'd9, 1'b0, OP_UNDEF_HI,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF));
      issue_instr(mk(OP_LDUR, 32'd7, 32'h0, 5'd5, 1'b0, OP_ADD, 32'd5, 32'd5));
      issue_instr(mk(OP_B, 32'hFFFF_FFFF, 32'h0, 5'd0, 1'b1, OP_ADD, 32'h0, 32'h0));
      wait_drained();
   endtask

   // Random programs, traffic shape changes per program
   task automatic test_random_programs();
      while (issued < RANDOM_ITEMS) begin
         sender_gaps = 1'($urandom_range(0, 1));
         rx_mode     = rx_mode_type'($urandom_range(RX_ALWAYS, RX_PATTERN));
         rx_pattern  = 8'($urandom_range(1, 255));
         run_program($urandom_range(1, 24));
      end
      wait_drained();
   endtask

   // Broken sequences: successor fields unrelated to the real next instruction
   task automatic test_noise();
      req_payload_type t;
      sender_gaps = 1;
      rx_mode     = RX_RANDOM;
      repeat (NOISE_ITEMS) begin
         t          = rand_instr();
         t.has_next = 1'($urandom_range(0, 1));
         t.next_op  = 4'($urandom_range(0, 15));
         t.next_a   = rand_operand(31);
         t.next_b   = rand_operand(31);
         issue_instr(t);
      end
      wait_drained();
   endtask

   // Receiver holds off while the sender keeps pushing
   task automatic test_backpressure();
      sender_gaps = 0;
      rx_mode     = RX_ALWAYS;
      fork
         begin
            rx_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rx_hold = 1'b0;
         end
      join_none
      run_program(50);
      wait_drained();
   endtask

   // Result-side ready
   always @(negedge clock) begin
      if (rx_hold) begin
         rsp_if.ready = 1'b0;
      end else begin
         case (rx_mode)
            RX_ALWAYS: rsp_if.ready = 1'b1;
            RX_RANDOM: rsp_if.ready = ($urandom_range(0, 3) != 0);
            default: begin
               rx_pattern   = {rx_pattern[6:0], rx_pattern[7]};
               rsp_if.ready = rx_pattern[0];
            end
         endcase
      end
   end

   function automatic bit field_bad(string name, logic [31:0] want, logic [31:0] got);
      if (want === got) return 0;
      if (mismatches < MAX_REPORTS)
         $display("result %0d: %s expected %h, got %h", checked, name, want, got);
      return 1;
   endfunction

   // Compare each result transaction with the oldest expectation
   always @(posedge clock) begin : check_results
      rsp_payload_type want;
      rsp_payload_type got;
      bit              bad;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         checked++;
         if (exec_results_q.size() == 0) begin
            if (mismatches < MAX_REPORTS)
               $display("result %0d: unexpected transaction %h", checked, got);
            mismatches++;
         end else begin
            want = exec_results_q.pop_front();
            bad  = field_bad("next_pc", 32'(want.next_pc), 32'(got.next_pc))
                 | field_bad("reg_write", 32'(want.reg_write), 32'(got.reg_write))
                 | field_bad("reg_index", 32'(want.reg_index), 32'(got.reg_index))
                 | field_bad("reg_value", want.reg_value, got.reg_value)
                 | field_bad("mem_write", 32'(want.mem_write), 32'(got.mem_write))
                 | field_bad("mem_index", 32'(want.mem_index), 32'(got.mem_index))
                 | field_bad("mem_value", want.mem_value, got.mem_value)
                 | field_bad("cycle_count", want.cycle_count, got.cycle_count);
            if (bad) mismatches++;
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Timeout with %0d results outstanding", exec_results_q.size());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      rx_hold        = 1'b0;
      rx_mode        = RX_ALWAYS;
      rx_pattern     = 8'h01;
      sender_gaps    = 0;
      burst_left     = 0;
      gpr            = '{default: '0};
      dmem           = '{default: '0};
      pc             = '0;
      cycles         = CYCLE_RESET;
      last_was_branch = 0;
      bubble_owed    = 0;

      repeat (4) @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random_programs();
      test_noise();
      test_backpressure();

      $display("Ran %0d instructions, %0d results checked: %0d taken CBZ, %0d stall bubbles.",
               issued, checked, n_taken, n_bubbles);
      $display("Covered all opcodes incl. undefined ones, hazards, PC wrap and a %0d-cycle hold.",
               HOLD_CYCLES);
      if (mismatches == 0 && exec_results_q.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire
